// ----- sv/osd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_pkg
// Shared types and defaults for the operand stack with depth access.
// ----------------------------------------------------------------------------
package osd_pkg;

	// default sizes
	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;

	// command codes
	typedef enum logic [2:0] {
		CMD_PUSH     = 3'd0,
		CMD_POP      = 3'd1,
		CMD_PEEK     = 3'd2,
		CMD_POKE     = 3'd3,
		CMD_DUP      = 3'd4,
		CMD_DROP     = 3'd5,
		CMD_CLEAR    = 3'd6,
		CMD_SET_FILL = 3'd7
	} cmd_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_RANGE     = 2'd3
	} err_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

endpackage

// ----- sv/osd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_cell
// One stack slot: holds a word, takes broadcast writes to its own address and
// forms one stage of the read chain, which moves one cell per cycle.
// ----------------------------------------------------------------------------
module osd_cell #(
	parameter int WORD_BITS = 32,
	parameter int AW        = 6,
	parameter int INDEX     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic [AW-1:0]        rd_addr,
	input  logic                 in_vld,
	input  logic [WORD_BITS-1:0] in_data,
	output logic                 out_vld,
	output logic [WORD_BITS-1:0] out_data
);

	localparam logic [AW-1:0] MY_ADDR = AW'(INDEX);

	logic [WORD_BITS-1:0] word_q;
	logic                 vld_q;
	logic [WORD_BITS-1:0] data_q;

	// slot storage
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == MY_ADDR)) begin
			word_q <= wr_data;
		end
	end

	// read chain stage: pick up own word when addressed, else pass along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= (rd_addr == MY_ADDR) ? word_q : in_data;
	end

	assign out_vld  = vld_q;
	assign out_data = data_q;

endmodule

// ----- sv/osd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_ctrl
// Command decode, fill counter, error checks, slot write port, read chain
// launch and the registered result.
// ----------------------------------------------------------------------------
module osd_ctrl
	import osd_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int AW        = $clog2(DEPTH),
	parameter int FW        = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           cmd,
	input  logic [WORD_BITS-1:0] value,
	input  logic [AW-1:0]        depth_index,
	input  logic [FW-1:0]        count,
	output logic                 busy,
	output logic                 done,
	output logic [WORD_BITS-1:0] data,
	output logic [FW-1:0]        fill,
	output logic [1:0]           error,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [WORD_BITS-1:0] wr_data,
	output logic [AW-1:0]        rd_addr,
	output logic                 launch,
	input  logic                 chain_vld,
	input  logic [WORD_BITS-1:0] chain_data
);

	localparam logic [FW-1:0] FULL = FW'(DEPTH);
	localparam logic [FW-1:0] ONE  = FW'(1);

	state_t state_q, state_d;

	logic [FW-1:0]        fill_q;
	logic                 launch_q;
	logic                 dup_q;
	logic [AW-1:0]        dup_addr_q;
	logic [AW-1:0]        rd_addr_q;
	logic                 done_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic [FW-1:0]        res_fill_q;
	err_t                 res_err_q;

	logic          accept;
	cmd_t          op;
	logic [FW-1:0] idx_ext;
	logic [FW-1:0] top_pos;
	logic [FW-1:0] idx_pos;
	logic [FW-1:0] nfill;
	err_t          nerr;
	logic          rd_go;
	logic          acc_wr;
	logic [AW-1:0] acc_wr_addr;
	logic [AW-1:0] acc_rd_addr;
	logic          dup_ok;
	logic          dup_wr;

	assign accept  = start && (state_q == ST_IDLE);
	assign op      = cmd_t'(cmd);
	assign idx_ext = FW'(depth_index);
	assign top_pos = fill_q - ONE;
	assign idx_pos = fill_q - ONE - idx_ext;

	// command decode and checks
	always_comb begin
		nfill       = fill_q;
		nerr        = ERR_OK;
		rd_go       = 1'b0;
		acc_wr      = 1'b0;
		acc_wr_addr = fill_q[AW-1:0];
		acc_rd_addr = top_pos[AW-1:0];
		dup_ok      = 1'b0;
		unique case (op)
			CMD_PUSH: begin
				if (fill_q >= FULL) begin
					nerr = ERR_OVERFLOW;
				end else begin
					acc_wr = 1'b1;
					nfill  = fill_q + ONE;
				end
			end
			CMD_POP: begin
				if (fill_q == '0) begin
					nerr = ERR_UNDERFLOW;
				end else begin
					rd_go = 1'b1;
					nfill = top_pos;
				end
			end
			CMD_PEEK: begin
				acc_rd_addr = idx_pos[AW-1:0];
				if (idx_ext >= fill_q) begin
					nerr = ERR_RANGE;
				end else begin
					rd_go = 1'b1;
				end
			end
			CMD_POKE: begin
				acc_wr_addr = idx_pos[AW-1:0];
				if (idx_ext >= fill_q) begin
					nerr = ERR_RANGE;
				end else begin
					acc_wr = 1'b1;
				end
			end
			CMD_DUP: begin
				if (fill_q == '0) begin
					nerr = ERR_UNDERFLOW;
				end else if (fill_q >= FULL) begin
					nerr = ERR_OVERFLOW;
				end else begin
					rd_go  = 1'b1;
					dup_ok = 1'b1;
					nfill  = fill_q + ONE;
				end
			end
			CMD_DROP: begin
				if (count > fill_q) begin
					nerr = ERR_UNDERFLOW;
				end else begin
					nfill = fill_q - count;
				end
			end
			CMD_CLEAR: begin
				nfill = '0;
			end
			CMD_SET_FILL: begin
				if (count > FULL) begin
					nerr = ERR_OVERFLOW;
				end else begin
					nfill = count;
				end
			end
			default: begin
				nerr = ERR_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && rd_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (chain_vld) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			launch_q <= 1'b0;
			dup_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && rd_go;
			done_q   <= (accept && !rd_go) || ((state_q == ST_SCAN) && chain_vld);
			if (accept) begin
				fill_q <= nfill;
				dup_q  <= dup_ok;
			end
		end
	end

	// result and pending read payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_q  <= acc_rd_addr;
			dup_addr_q <= fill_q[AW-1:0];
			res_fill_q <= nfill;
			res_err_q  <= nerr;
			res_data_q <= '0;
		end else if ((state_q == ST_SCAN) && chain_vld) begin
			res_data_q <= chain_data;
		end
	end

	// slot write port: direct writes at accept, duplicate write after the read
	assign dup_wr  = (state_q == ST_SCAN) && chain_vld && dup_q;
	assign wr_en   = (accept && acc_wr) || dup_wr;
	assign wr_addr = dup_wr ? dup_addr_q : acc_wr_addr;
	assign wr_data = dup_wr ? chain_data : value;

	assign rd_addr = rd_addr_q;
	assign launch  = launch_q;
	assign busy    = (state_q == ST_SCAN);
	assign done    = done_q;
	assign data    = res_data_q;
	assign fill    = res_fill_q;
	assign error   = res_err_q;

endmodule

// ----- sv/operand_stack_with_depth_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operand_stack_with_depth_access
// Word-wide LIFO operand stack with peek and poke at a depth below the top.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command gives
// exactly one result, shown for a single cycle with done high; the receiver
// must take it then. Push, poke, drop count, clear and set fill, and any
// command that fails its check, return their result in the cycle after the
// accept and the next command may follow at once. Pop, peek and duplicate
// read a slot through the row of DEPTH cells, one cell per cycle, so they
// hold busy high until the read has left the last cell, and done comes in
// the cycle in which busy falls again. A failing command returns its error
// code, zero data and the unchanged fill.
// ----------------------------------------------------------------------------
module operand_stack_with_depth_access
	import osd_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int AW        = $clog2(DEPTH),
	parameter int FW        = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           cmd,
	input  logic [WORD_BITS-1:0] value,
	input  logic [AW-1:0]        depth_index,
	input  logic [FW-1:0]        count,
	output logic                 done,
	output logic [WORD_BITS-1:0] data,
	output logic [FW-1:0]        fill,
	output logic [1:0]           error
);

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [AW-1:0]        rd_addr;
	logic                 launch;
	logic                 chain_vld [DEPTH+1];
	logic [WORD_BITS-1:0] chain_data [DEPTH+1];

	// controller
	osd_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.AW        (AW),
		.FW        (FW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.value       (value),
		.depth_index (depth_index),
		.count       (count),
		.busy        (busy),
		.done        (done),
		.data        (data),
		.fill        (fill),
		.error       (error),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.launch      (launch),
		.chain_vld   (chain_vld[DEPTH]),
		.chain_data  (chain_data[DEPTH])
	);

	// head of the read chain
	assign chain_vld[0]  = launch;
	assign chain_data[0] = '0;

	// row of slot cells
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		osd_cell #(
			.WORD_BITS (WORD_BITS),
			.AW        (AW),
			.INDEX     (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_addr  (wr_addr),
			.wr_data  (wr_data),
			.rd_addr  (rd_addr),
			.in_vld   (chain_vld[k]),
			.in_data  (chain_data[k]),
			.out_vld  (chain_vld[k+1]),
			.out_data (chain_data[k+1])
		);
	end

`ifndef SYNTHESIS
	// a result never shows while a read is still in flight
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted item either answers next cycle or starts a read
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted item neither answered nor reading");

	// fill never goes above the stack size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (fill <= FW'(DEPTH)))
		else $error("fill above depth");

	// a failed command returns zero data
	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error != ERR_OK)) |-> (data == '0))
		else $error("nonzero data with error");
`endif

endmodule
